>>> hw/rtl/imalu_pkg.sv
package imalu_pkg;

   localparam int IMALU_DATA_WIDTH = 64;
   localparam int OP_WIDTH         = 3;
   localparam int STATUS_WIDTH     = 2;
   localparam int FACT_CAP         = 130;
   localparam int CNT_WIDTH        = $clog2(FACT_CAP + 2);

   localparam logic [OP_WIDTH-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_SUB  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_MUL  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_DIV  = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_POW  = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_FACT = 3'd6;

   localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_DIVZERO = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_MUL_WAIT,
      S_DIV,
      S_DIV_TAKE,
      S_POW_CHECK,
      S_POW_MWAIT,
      S_POW_SQ,
      S_POW_SWAIT,
      S_FACT_CHECK,
      S_FACT_WAIT,
      S_FINISH
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DP_IDLE,
      DP_LOAD,
      DP_ADD,
      DP_SUB,
      DP_CLEAR,
      DP_MUL_AB,
      DP_MUL_ACC_SQ,
      DP_MUL_SQ_SQ,
      DP_MUL_ACC_CNT,
      DP_TAKE_ACC,
      DP_TAKE_SQ,
      DP_TAKE_FACT,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_DIV_TAKE,
      DP_POW_INIT,
      DP_FACT_INIT,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type               op;
      logic [STATUS_WIDTH-1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic b_zero;
      logic b_lsb;
      logic div_last;
      logic fact_end;
      logic acc_zero;
   } dp_stat_type;

endpackage

>>> hw/rtl/imalu_if.sv
interface imalu_req_if
   import imalu_pkg::*;
#(
   parameter int DATA_WIDTH = IMALU_DATA_WIDTH
);
   logic                  valid;
   logic                  ready;
   logic [OP_WIDTH-1:0]   operation;
   logic [DATA_WIDTH-1:0] operand_a;
   logic [DATA_WIDTH-1:0] operand_b;

   modport source (output valid, output operation, output operand_a, output operand_b,
                   input ready);
   modport sink (input valid, input operation, input operand_a, input operand_b,
                 output ready);
endinterface

interface imalu_rsp_if
   import imalu_pkg::*;
#(
   parameter int DATA_WIDTH = IMALU_DATA_WIDTH
);
   logic                    valid;
   logic                    ready;
   logic [DATA_WIDTH-1:0]   result_value;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink (input valid, input result_value, input status, output ready);
endinterface

>>> hw/rtl/imalu_mul.sv
module imalu_mul
   import imalu_pkg::*;
#(
   parameter int DATA_WIDTH = IMALU_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] x,
   input  logic [DATA_WIDTH-1:0] y,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] product
);

   localparam int H  = (DATA_WIDTH + 1) / 2;
   localparam int LW = DATA_WIDTH - H;

   localparam logic [1:0] STEP_LO_LO = 2'd0;
   localparam logic [1:0] STEP_LO_HI = 2'd1;
   localparam logic [1:0] STEP_HI_LO = 2'd2;

   logic [DATA_WIDTH-1:0] x_ff, y_ff, prod_ff, prod_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [1:0]            step_ff, step_in;
   logic [H-1:0]          mx, my;
   logic [2*H-1:0]        m, m_sh;
   logic [LW-1:0]         xh, yh;

   assign xh = x_ff[DATA_WIDTH-1:H];
   assign yh = y_ff[DATA_WIDTH-1:H];

   always_comb begin
      mx = (step_ff == STEP_HI_LO) ? H'(xh) : x_ff[H-1:0];
      my = (step_ff == STEP_LO_HI) ? H'(yh) : y_ff[H-1:0];
      m = (2*H)'(mx) * (2*H)'(my);
      m_sh = m << H;
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_LO_LO;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_LO_LO: begin
               prod_in = DATA_WIDTH'(m);
               step_in = STEP_LO_HI;
            end
            STEP_LO_HI: begin
               prod_in = prod_ff + DATA_WIDTH'(m_sh);
               step_in = STEP_HI_LO;
            end
            default: begin
               prod_in = prod_ff + DATA_WIDTH'(m_sh);
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LO_LO;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x;
         y_ff <= y;
      end
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

>>> hw/rtl/imalu_dp.sv
module imalu_dp
   import imalu_pkg::*;
#(
   parameter int DATA_WIDTH = IMALU_DATA_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   input  logic [DATA_WIDTH-1:0]   operand_a,
   input  logic [DATA_WIDTH-1:0]   operand_b,
   output dp_stat_type             stat,
   output logic [DATA_WIDTH-1:0]   result_value,
   output logic [STATUS_WIDTH-1:0] status
);

   logic [DATA_WIDTH-1:0]   a_ff, a_in, b_ff, b_in, acc_ff, acc_in, rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]   result_ff, result_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in, lim_ff, lim_in;
   logic [DATA_WIDTH:0]     rem_shift, diff;
   logic [DATA_WIDTH-1:0]   n_max;
   logic                    mul_start, mul_done;
   logic [DATA_WIDTH-1:0]   mul_x, mul_y, mul_p;

   imalu_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .done    (mul_done),
      .product (mul_p)
   );

   always_comb begin
      mul_start = 1'b0;
      mul_x = acc_ff;
      mul_y = a_ff;
      case (cmd.op)
         DP_MUL_AB: begin
            mul_start = 1'b1;
            mul_x = a_ff;
            mul_y = b_ff;
         end
         DP_MUL_ACC_SQ: begin
            mul_start = 1'b1;
         end
         DP_MUL_SQ_SQ: begin
            mul_start = 1'b1;
            mul_x = a_ff;
         end
         DP_MUL_ACC_CNT: begin
            mul_start = 1'b1;
            mul_y = DATA_WIDTH'(cnt_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rem_shift = {rem_ff, a_ff[DATA_WIDTH-1]};
      diff = rem_shift - {1'b0, b_ff};
      n_max = (a_ff > b_ff) ? a_ff : b_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      lim_in = lim_ff;
      result_in = result_ff;
      status_in = status_ff;
      case (cmd.op)
         DP_LOAD: begin
            a_in = operand_a;
            b_in = operand_b;
         end
         DP_ADD: acc_in = a_ff + b_ff;
         DP_SUB: acc_in = a_ff - b_ff;
         DP_CLEAR: acc_in = '0;
         DP_TAKE_ACC: acc_in = mul_p;
         DP_TAKE_SQ: begin
            a_in = mul_p;
            b_in = b_ff >> 1;
         end
         DP_TAKE_FACT: begin
            acc_in = mul_p;
            cnt_in = cnt_ff + CNT_WIDTH'(1);
         end
         DP_DIV_INIT: begin
            rem_in = '0;
            cnt_in = CNT_WIDTH'(DATA_WIDTH);
         end
         DP_DIV_STEP: begin
            if (!diff[DATA_WIDTH]) begin
               rem_in = diff[DATA_WIDTH-1:0];
            end else begin
               rem_in = rem_shift[DATA_WIDTH-1:0];
            end
            a_in = {a_ff[DATA_WIDTH-2:0], !diff[DATA_WIDTH]};
            cnt_in = cnt_ff - CNT_WIDTH'(1);
         end
         DP_DIV_TAKE: acc_in = a_ff;
         DP_POW_INIT: acc_in = DATA_WIDTH'(1);
         DP_FACT_INIT: begin
            acc_in = DATA_WIDTH'(1);
            cnt_in = CNT_WIDTH'(2);
            if (n_max < DATA_WIDTH'(FACT_CAP)) begin
               lim_in = n_max[CNT_WIDTH-1:0];
            end else begin
               lim_in = CNT_WIDTH'(FACT_CAP);
            end
         end
         DP_OUT: begin
            result_in = acc_ff;
            status_in = cmd.status;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      lim_ff <= lim_in;
      result_ff <= result_in;
      status_ff <= status_in;
   end

   assign stat.mul_done = mul_done;
   assign stat.b_zero   = (b_ff == '0);
   assign stat.b_lsb    = b_ff[0];
   assign stat.div_last = (cnt_ff == CNT_WIDTH'(1));
   assign stat.fact_end = (cnt_ff > lim_ff);
   assign stat.acc_zero = (acc_ff == '0);

   assign result_value = result_ff;
   assign status       = status_ff;

endmodule

>>> hw/rtl/imalu_ctrl.sv
module imalu_ctrl
   import imalu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OP_WIDTH-1:0] req_operation,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dp_stat_type         stat,
   output dp_cmd_type          cmd
);

   ctrl_state_type          state_ff, state_in;
   logic [OP_WIDTH-1:0]     op_ff, op_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      cmd.op = DP_IDLE;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_LOAD;
               op_in = req_operation;
               status_in = ST_OK;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (op_ff)
               OP_ADD: begin
                  cmd.op = DP_ADD;
                  state_in = S_FINISH;
               end
               OP_SUB: begin
                  cmd.op = DP_SUB;
                  state_in = S_FINISH;
               end
               OP_MUL: begin
                  cmd.op = DP_MUL_AB;
                  state_in = S_MUL_WAIT;
               end
               OP_DIV: begin
                  if (stat.b_zero) begin
                     cmd.op = DP_CLEAR;
                     status_in = ST_DIVZERO;
                     state_in = S_FINISH;
                  end else begin
                     cmd.op = DP_DIV_INIT;
                     state_in = S_DIV;
                  end
               end
               OP_POW: begin
                  cmd.op = DP_POW_INIT;
                  state_in = S_POW_CHECK;
               end
               OP_FACT: begin
                  cmd.op = DP_FACT_INIT;
                  state_in = S_FACT_CHECK;
               end
               default: begin
                  cmd.op = DP_CLEAR;
                  status_in = ST_INVALID;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_MUL_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = DP_TAKE_ACC;
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            cmd.op = DP_DIV_STEP;
            if (stat.div_last) begin
               state_in = S_DIV_TAKE;
            end
         end
         S_DIV_TAKE: begin
            cmd.op = DP_DIV_TAKE;
            state_in = S_FINISH;
         end
         S_POW_CHECK: begin
            if (stat.b_zero) begin
               state_in = S_FINISH;
            end else if (stat.b_lsb) begin
               cmd.op = DP_MUL_ACC_SQ;
               state_in = S_POW_MWAIT;
            end else begin
               cmd.op = DP_MUL_SQ_SQ;
               state_in = S_POW_SWAIT;
            end
         end
         S_POW_MWAIT: begin
            if (stat.mul_done) begin
               cmd.op = DP_TAKE_ACC;
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            cmd.op = DP_MUL_SQ_SQ;
            state_in = S_POW_SWAIT;
         end
         S_POW_SWAIT: begin
            if (stat.mul_done) begin
               cmd.op = DP_TAKE_SQ;
               state_in = S_POW_CHECK;
            end
         end
         S_FACT_CHECK: begin
            if (stat.fact_end || stat.acc_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.op = DP_MUL_ACC_CNT;
               state_in = S_FACT_WAIT;
            end
         end
         S_FACT_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = DP_TAKE_FACT;
               state_in = S_FACT_CHECK;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/multicycle_integer_alu.sv
// Unsigned integer ALU, one request in and one result out, one request in
// flight at a time. Divide uses a restoring divider, one quotient bit per
// cycle. Power squares once per exponent bit up to its highest set bit and
// multiplies once more per set bit; factorial multiplies by each factor
// up to min(n,130), stopping once the product wraps to zero (n=66 at 64
// bits). Every product goes through one shared half-width multiplier that
// takes three partial products. A new request is taken while the previous
// result is still waiting in the output register.
module multicycle_integer_alu
   import imalu_pkg::*;
#(
   parameter int DATA_WIDTH = IMALU_DATA_WIDTH
) (
   input logic        clock,
   input logic        reset,
   imalu_req_if.sink  req_ch,
   imalu_rsp_if.source rsp_ch
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   imalu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   imalu_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .operand_a    (req_ch.operand_a),
      .operand_b    (req_ch.operand_b),
      .stat         (stat),
      .result_value (rsp_ch.result_value),
      .status       (rsp_ch.status)
   );

endmodule

>>> bench/tb_top.sv
module tb_top;
   import imalu_pkg::*;

   localparam int W          = IMALU_DATA_WIDTH;
   localparam int LONG_STALL = 300;
   localparam int SETTLE     = 100;

   localparam logic [OP_WIDTH-1:0] OP_UNUSED_LO = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [W-1:0]            value;
      logic [STATUS_WIDTH-1:0] status;
   } alu_result_type;

   logic clock;
   logic reset;

   imalu_req_if #(.DATA_WIDTH(W)) req_bus ();
   imalu_rsp_if #(.DATA_WIDTH(W)) rsp_bus ();

   multicycle_integer_alu #(.DATA_WIDTH(W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   alu_result_type expected_results[$];
   int             mismatch_count;
   bit             tx_bursts;
   bit             rx_bursts;
   bit             long_stall_pending;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic alu_result_type compute_alu(input logic [OP_WIDTH-1:0] op,
                                                  input logic [W-1:0] a,
                                                  input logic [W-1:0] b);
      alu_result_type r;
      logic [W-1:0]   acc;
      logic [W-1:0]   sq;
      logic [W-1:0]   e;
      logic [W-1:0]   n;
      logic [W-1:0]   lim;
      logic [W-1:0]   i;
      r.value  = '0;
      r.status = ST_OK;
      case (op)
         OP_ADD: r.value = a + b;
         OP_SUB: r.value = a - b;
         OP_MUL: r.value = a * b;
         OP_DIV: begin
            if (b == '0) r.status = ST_DIVZERO;
            else r.value = a / b;
         end
         OP_POW: begin
            acc = W'(1);
            sq  = a;
            e   = b;
            while (e != '0) begin
               if (e[0]) acc = acc * sq;
               sq = sq * sq;
               e  = e >> 1;
            end
            r.value = acc;
         end
         OP_FACT: begin
            n   = (a > b) ? a : b;
            lim = (n < W'(FACT_CAP)) ? n : W'(FACT_CAP);
            acc = W'(1);
            for (i = W'(2); i <= lim; i++) begin
               acc = acc * i;
               if (acc == '0) break;
            end
            r.value = acc;
         end
         default: r.status = ST_INVALID;
      endcase
      return r;
   endfunction

   function automatic logic [W-1:0] pick_operand();
      logic [W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = W'($urandom_range(0, 255));
         3: v = W'(1) << $urandom_range(0, W - 1);
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // caller is at a falling edge; returns at a falling edge after the transfer
   task automatic send_request(input logic [OP_WIDTH-1:0] op,
                               input logic [W-1:0] a,
                               input logic [W-1:0] b);
      req_bus.valid     = 1'b1;
      req_bus.operation = op;
      req_bus.operand_a = a;
      req_bus.operand_b = b;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(compute_alu(op, a, b));
      @(negedge clock);
      if (tx_bursts && $urandom_range(0, 4) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   task automatic send_random_request();
      logic [OP_WIDTH-1:0] op;
      logic [W-1:0]        a;
      logic [W-1:0]        b;
      op = OP_WIDTH'($urandom_range(0, 7));
      a  = pick_operand();
      b  = pick_operand();
      case (op)
         OP_POW: begin
            if ($urandom_range(0, 9) < 7) b = W'($urandom_range(0, 40));
         end
         OP_FACT: begin
            a = W'($urandom_range(0, 90));
            if ($urandom_range(0, 9) < 8) b = W'($urandom_range(0, 90));
         end
         OP_DIV: begin
            if ($urandom_range(0, 7) == 0) b = '0;
         end
         default: ;
      endcase
      send_request(op, a, b);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver side
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_pending) begin
            rsp_bus.ready      = 1'b0;
            long_stall_pending = 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
         end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer value %h status %0d",
                   rsp_bus.result_value, rsp_bus.status);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.result_value !== want.value) begin
               $error("result_value expected %h actual %h", want.value,
                      rsp_bus.result_value);
               mismatch_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_directed();
      tx_bursts = 1'b1;
      rx_bursts = 1'b1;
      send_request(OP_ADD, '1, W'(1));
      send_request(OP_ADD, '0, '0);
      send_request(OP_SUB, '0, W'(1));
      send_request(OP_SUB, '1, '1);
      send_request(OP_MUL, '1, '1);
      send_request(OP_MUL, {$urandom, $urandom}, {$urandom, $urandom});
      send_request(OP_DIV, {$urandom, $urandom}, '0);
      send_request(OP_DIV, '1, W'(1));
      send_request(OP_DIV, W'(5), W'(7));
      send_request(OP_DIV, '1, '1);
      send_request(OP_POW, '0, '0);
      send_request(OP_POW, '1, '0);
      send_request(OP_POW, W'(2), W'(63));
      send_request(OP_POW, W'(2), W'(64));
      send_request(OP_POW, '1, '1);
      send_request(OP_POW, W'(3), {$urandom, $urandom});
      send_request(OP_FACT, '0, '0);
      send_request(OP_FACT, W'(1), '0);
      send_request(OP_FACT, W'(3), W'(20));
      send_request(OP_FACT, W'(65), W'(2));
      send_request(OP_FACT, W'(66), W'(0));
      send_request(OP_FACT, '1, W'(4));
      send_request(OP_UNUSED_LO, '1, '1);
      send_request(OP_UNUSED_HI, '1, '1);
      drain_results();
   endtask

   task automatic test_random_mix();
      tx_bursts = 1'b1;
      rx_bursts = 1'b1;
      repeat (1550) send_random_request();
      drain_results();
   endtask

   task automatic test_output_backpressure();
      tx_bursts          = 1'b0;
      rx_bursts          = 1'b0;
      long_stall_pending = 1'b1;
      repeat (12) send_request(OP_WIDTH'($urandom_range(1, 3)), pick_operand(),
                               pick_operand());
      drain_results();
   endtask

   task automatic test_streaming();
      tx_bursts = 1'b0;
      rx_bursts = 1'b0;
      repeat (220) send_random_request();
      drain_results();
   endtask

   initial begin
      reset              = 1'b1;
      mismatch_count     = 0;
      tx_bursts          = 1'b0;
      rx_bursts          = 1'b0;
      long_stall_pending = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.operation  = '0;
      req_bus.operand_a  = '0;
      req_bus.operand_b  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_mix();
      test_output_backpressure();
      test_streaming();

      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/imalu_pkg.sv
hw/rtl/imalu_if.sv
hw/rtl/imalu_mul.sv
hw/rtl/imalu_dp.sv
hw/rtl/imalu_ctrl.sv
hw/rtl/multicycle_integer_alu.sv
bench/tb_top.sv
